/* rtl/core/cfci_pkg.sv */
// ---------------------------------------------------------------------------
// cfci_pkg
// Shared widths, face codes and types for the cube face cell index block.
// ---------------------------------------------------------------------------
package cfci_pkg;

    localparam int DIR_W  = 16;   // signed direction component
    localparam int MAG_W  = 16;   // magnitude, up to 32768
    localparam int SUM_W  = 17;   // c + m and 2m, up to 65536
    localparam int GRID_W = 4;
    localparam int IDX_W  = 9;
    localparam int FACE_W = 3;
    localparam int CELL_W = 3;

    localparam int MAX_GRID_DEF = 8;

    localparam logic [GRID_W-1:0] GRID_RESET = 4'd3;

    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd0;
    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd1;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd2;
    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd3;
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd4;
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd5;

    typedef struct packed {
        logic [FACE_W-1:0] face;
        logic              zero;
    } side_t;

endpackage

/* rtl/core/cfci_if.sv */
// ---------------------------------------------------------------------------
// cfci_if
// Valid/ready channels: direction items in, cell items out.
// ---------------------------------------------------------------------------
interface cfci_dir_if;
    import cfci_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;

    modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
    modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface cfci_cell_if;
    import cfci_pkg::*;

    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  cell_index;
    logic [FACE_W-1:0] face;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic              zero_vector;

    modport source (output valid, output cell_index, output face, output cell_x,
                    output cell_y, output zero_vector, input ready);
    modport sink   (input valid, input cell_index, input face, input cell_x,
                    input cell_y, input zero_vector, output ready);
endinterface

/* rtl/core/cfci_select.sv */
// ---------------------------------------------------------------------------
// cfci_select
// Major axis pick, face, minor components, then scaled numerators (c+m)*N
// and divisor 2m. Two register stages.
// ---------------------------------------------------------------------------
module cfci_select #(
    parameter int MAX_GRID = cfci_pkg::MAX_GRID_DEF,
    localparam int NW = $clog2(MAX_GRID + 1),
    localparam int RW = cfci_pkg::SUM_W + NW
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [cfci_pkg::GRID_W-1:0]  grid_size,
    cfci_dir_if.sink                     dir_chan,
    output logic                         out_valid,
    input  logic                         out_ready,
    output cfci_pkg::side_t              out_side,
    output logic [NW-1:0]                out_n,
    output logic [cfci_pkg::SUM_W-1:0]   out_div,
    output logic [RW-1:0]                out_num1,
    output logic [RW-1:0]                out_num2
);
    import cfci_pkg::*;

    logic [MAG_W-1:0]        ax, ay, az;
    logic signed [DIR_W:0]   x_ext, y_ext, z_ext;
    logic [NW-1:0]           a_n_next;
    logic [MAG_W-1:0]        a_m_next;
    logic signed [DIR_W-1:0] a_c1_next, a_c2_next;
    side_t                   a_side_next;

    logic                    a_valid_reg;
    side_t                   a_side_reg;
    logic [NW-1:0]           a_n_reg;
    logic [MAG_W-1:0]        a_m_reg;
    logic signed [DIR_W-1:0] a_c1_reg, a_c2_reg;
    logic                    a_ready;

    logic [SUM_W:0]          s1_wide, s2_wide;
    logic [RW-1:0]           b_num1_next, b_num2_next;
    logic [SUM_W-1:0]        b_div_next;

    logic                    b_valid_reg;
    side_t                   b_side_reg;
    logic [NW-1:0]           b_n_reg;
    logic [SUM_W-1:0]        b_div_reg;
    logic [RW-1:0]           b_num1_reg, b_num2_reg;
    logic                    b_ready;

    // stage A
    always_comb
    begin
        x_ext = {dir_chan.dir_x[DIR_W-1], dir_chan.dir_x};
        y_ext = {dir_chan.dir_y[DIR_W-1], dir_chan.dir_y};
        z_ext = {dir_chan.dir_z[DIR_W-1], dir_chan.dir_z};
        ax = x_ext[DIR_W] ? MAG_W'(-x_ext) : MAG_W'(x_ext);
        ay = y_ext[DIR_W] ? MAG_W'(-y_ext) : MAG_W'(y_ext);
        az = z_ext[DIR_W] ? MAG_W'(-z_ext) : MAG_W'(z_ext);

        if (grid_size == '0)
        begin
            a_n_next = NW'(1);
        end
        else if (int'(grid_size) > MAX_GRID)
        begin
            a_n_next = NW'(MAX_GRID);
        end
        else
        begin
            a_n_next = NW'(grid_size);
        end

        a_side_next.zero = (ax == '0) && (ay == '0) && (az == '0);
        if (ax >= ay && ax >= az)
        begin
            a_m_next         = ax;
            a_side_next.face = dir_chan.dir_x[DIR_W-1] ? FACE_NEG_X : FACE_POS_X;
            a_c1_next        = dir_chan.dir_y;
            a_c2_next        = dir_chan.dir_z;
        end
        else if (ay >= az)
        begin
            a_m_next         = ay;
            a_side_next.face = dir_chan.dir_y[DIR_W-1] ? FACE_NEG_Y : FACE_POS_Y;
            a_c1_next        = dir_chan.dir_z;
            a_c2_next        = dir_chan.dir_x;
        end
        else
        begin
            a_m_next         = az;
            a_side_next.face = dir_chan.dir_z[DIR_W-1] ? FACE_NEG_Z : FACE_POS_Z;
            a_c1_next        = dir_chan.dir_x;
            a_c2_next        = dir_chan.dir_y;
        end
    end

    assign a_ready        = !a_valid_reg || b_ready;
    assign dir_chan.ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= dir_chan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dir_chan.valid && a_ready)
        begin
            a_side_reg <= a_side_next;
            a_n_reg    <= a_n_next;
            a_m_reg    <= a_m_next;
            a_c1_reg   <= a_c1_next;
            a_c2_reg   <= a_c2_next;
        end
    end

    // stage B: c + m lies in [0, 2m]
    always_comb
    begin
        s1_wide     = (SUM_W+1)'(signed'(a_c1_reg)) + (SUM_W+1)'(a_m_reg);
        s2_wide     = (SUM_W+1)'(signed'(a_c2_reg)) + (SUM_W+1)'(a_m_reg);
        b_num1_next = RW'(s1_wide[SUM_W-1:0]) * RW'(a_n_reg);
        b_num2_next = RW'(s2_wide[SUM_W-1:0]) * RW'(a_n_reg);
        b_div_next  = {a_m_reg, 1'b0};
    end

    assign b_ready = !b_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_valid_reg && b_ready)
        begin
            b_side_reg <= a_side_reg;
            b_n_reg    <= a_n_reg;
            b_div_reg  <= b_div_next;
            b_num1_reg <= b_num1_next;
            b_num2_reg <= b_num2_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_side  = b_side_reg;
    assign out_n     = b_n_reg;
    assign out_div   = b_div_reg;
    assign out_num1  = b_num1_reg;
    assign out_num2  = b_num2_reg;

endmodule

/* rtl/core/cfci_div_cell.sv */
// ---------------------------------------------------------------------------
// cfci_div_cell
// One restoring-division cell: settles quotient bit BIT of both cell
// coordinates and passes the partial remainders to the next cell.
// ---------------------------------------------------------------------------
module cfci_div_cell #(
    parameter int MAX_GRID = cfci_pkg::MAX_GRID_DEF,
    parameter int BIT      = 0,
    localparam int NW = $clog2(MAX_GRID + 1),
    localparam int RW = cfci_pkg::SUM_W + NW
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  cfci_pkg::side_t             in_side,
    input  logic [NW-1:0]               in_n,
    input  logic [cfci_pkg::SUM_W-1:0]  in_div,
    input  logic [RW-1:0]               in_rem1,
    input  logic [RW-1:0]               in_rem2,
    input  logic [NW-1:0]               in_q1,
    input  logic [NW-1:0]               in_q2,
    output logic                        out_valid,
    input  logic                        out_ready,
    output cfci_pkg::side_t             out_side,
    output logic [NW-1:0]               out_n,
    output logic [cfci_pkg::SUM_W-1:0]  out_div,
    output logic [RW-1:0]               out_rem1,
    output logic [RW-1:0]               out_rem2,
    output logic [NW-1:0]               out_q1,
    output logic [NW-1:0]               out_q2
);
    import cfci_pkg::*;

    logic [RW-1:0]    shifted;
    logic             ge1, ge2;
    logic [RW-1:0]    rem1_next, rem2_next;
    logic [NW-1:0]    q1_next, q2_next;

    logic             valid_reg;
    side_t            side_reg;
    logic [NW-1:0]    n_reg;
    logic [SUM_W-1:0] div_reg;
    logic [RW-1:0]    rem1_reg, rem2_reg;
    logic [NW-1:0]    q1_reg, q2_reg;

    always_comb
    begin
        shifted   = RW'(in_div) << BIT;
        ge1       = in_rem1 >= shifted;
        ge2       = in_rem2 >= shifted;
        rem1_next = ge1 ? in_rem1 - shifted : in_rem1;
        rem2_next = ge2 ? in_rem2 - shifted : in_rem2;
        q1_next      = in_q1;
        q1_next[BIT] = ge1;
        q2_next      = in_q2;
        q2_next[BIT] = ge2;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            side_reg <= in_side;
            n_reg    <= in_n;
            div_reg  <= in_div;
            rem1_reg <= rem1_next;
            rem2_reg <= rem2_next;
            q1_reg   <= q1_next;
            q2_reg   <= q2_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_n     = n_reg;
    assign out_div   = div_reg;
    assign out_rem1  = rem1_reg;
    assign out_rem2  = rem2_reg;
    assign out_q1    = q1_reg;
    assign out_q2    = q2_reg;

endmodule

/* rtl/core/cfci_assemble.sv */
// ---------------------------------------------------------------------------
// cfci_assemble
// Clamps the quotients to N-1, forms the linear index and holds the
// result item in the output register.
// ---------------------------------------------------------------------------
module cfci_assemble #(
    parameter int MAX_GRID = cfci_pkg::MAX_GRID_DEF,
    localparam int NW = $clog2(MAX_GRID + 1),
    localparam int IW = cfci_pkg::FACE_W + 2 * NW + 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  cfci_pkg::side_t in_side,
    input  logic [NW-1:0]   in_n,
    input  logic [NW-1:0]   in_q1,
    input  logic [NW-1:0]   in_q2,
    cfci_cell_if.source     result
);
    import cfci_pkg::*;

    logic [NW-1:0]     cx, cy;
    logic [IW-1:0]     idx_full;
    logic [IDX_W-1:0]  idx_next;
    logic [FACE_W-1:0] face_next;
    logic [CELL_W-1:0] cell_x_next, cell_y_next;

    logic              valid_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [FACE_W-1:0] face_reg;
    logic [CELL_W-1:0] cell_x_reg, cell_y_reg;
    logic              zero_reg;

    always_comb
    begin
        cx = (in_q1 >= in_n) ? in_n - NW'(1) : in_q1;
        cy = (in_q2 >= in_n) ? in_n - NW'(1) : in_q2;
        idx_full = IW'(in_side.face) * IW'(in_n) * IW'(in_n)
                 + IW'(cx) + IW'(in_n) * IW'(cy);
        if (in_side.zero)
        begin
            idx_next    = '0;
            face_next   = '0;
            cell_x_next = '0;
            cell_y_next = '0;
        end
        else
        begin
            idx_next    = IDX_W'(idx_full);
            face_next   = in_side.face;
            cell_x_next = CELL_W'(cx);
            cell_y_next = CELL_W'(cy);
        end
    end

    assign in_ready = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            idx_reg    <= idx_next;
            face_reg   <= face_next;
            cell_x_reg <= cell_x_next;
            cell_y_reg <= cell_y_next;
            zero_reg   <= in_side.zero;
        end
    end

    assign result.valid       = valid_reg;
    assign result.cell_index  = idx_reg;
    assign result.face        = face_reg;
    assign result.cell_x      = cell_x_reg;
    assign result.cell_y      = cell_y_reg;
    assign result.zero_vector = zero_reg;

endmodule

/* rtl/core/cube_face_cell_index.sv */
// ---------------------------------------------------------------------------
// cube_face_cell_index
// Cube map face selection and exact cell coordinates for a direction vector.
// ---------------------------------------------------------------------------
//  port       kind               item
//  dir_chan   valid/ready sink   dir_x, dir_y, dir_z
//  result     valid/ready source cell_index, face, cell_x, cell_y, zero_vector
//  cfg_we     write strobe       cfg_wdata -> grid_size
//
//  One item per cycle unless a held result backs up the pipe; items pass
//  select, the chain of division cells (one quotient bit per cell), assemble.
//  Each stage has its own valid; ready ripples back stage by stage, so
//  bubbles close up and a held result stalls the input only once every
//  stage holds an item (7 items at MAX_GRID 8).
//  Reset clears all stage valids and sets grid_size to 3.
// ---------------------------------------------------------------------------
module cube_face_cell_index #(
    parameter int MAX_GRID = cfci_pkg::MAX_GRID_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [cfci_pkg::GRID_W-1:0] cfg_wdata,
    cfci_dir_if.sink                    dir_chan,
    cfci_cell_if.source                 result
);
    import cfci_pkg::*;

    localparam int NW = $clog2(MAX_GRID + 1);
    localparam int RW = SUM_W + NW;

    logic [GRID_W-1:0] grid_size_reg;

    logic             valid_c [0:NW];
    logic             ready_c [0:NW];
    side_t            side_c  [0:NW];
    logic [NW-1:0]    n_c     [0:NW];
    logic [SUM_W-1:0] div_c   [0:NW];
    logic [RW-1:0]    rem1_c  [0:NW];
    logic [RW-1:0]    rem2_c  [0:NW];
    logic [NW-1:0]    q1_c    [0:NW];
    logic [NW-1:0]    q2_c    [0:NW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= GRID_RESET;
        end
        else if (cfg_we)
        begin
            grid_size_reg <= cfg_wdata;
        end
    end

    cfci_select #(.MAX_GRID(MAX_GRID)) u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .grid_size (grid_size_reg),
        .dir_chan  (dir_chan),
        .out_valid (valid_c[0]),
        .out_ready (ready_c[0]),
        .out_side  (side_c[0]),
        .out_n     (n_c[0]),
        .out_div   (div_c[0]),
        .out_num1  (rem1_c[0]),
        .out_num2  (rem2_c[0])
    );

    assign q1_c[0] = '0;
    assign q2_c[0] = '0;

    for (genvar i = 0; i < NW; i++)
    begin : g_cell
        cfci_div_cell #(.MAX_GRID(MAX_GRID), .BIT(NW - 1 - i)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_c[i]),
            .in_ready  (ready_c[i]),
            .in_side   (side_c[i]),
            .in_n      (n_c[i]),
            .in_div    (div_c[i]),
            .in_rem1   (rem1_c[i]),
            .in_rem2   (rem2_c[i]),
            .in_q1     (q1_c[i]),
            .in_q2     (q2_c[i]),
            .out_valid (valid_c[i+1]),
            .out_ready (ready_c[i+1]),
            .out_side  (side_c[i+1]),
            .out_n     (n_c[i+1]),
            .out_div   (div_c[i+1]),
            .out_rem1  (rem1_c[i+1]),
            .out_rem2  (rem2_c[i+1]),
            .out_q1    (q1_c[i+1]),
            .out_q2    (q2_c[i+1])
        );
    end

    cfci_assemble #(.MAX_GRID(MAX_GRID)) u_assemble (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (valid_c[NW]),
        .in_ready (ready_c[NW]),
        .in_side  (side_c[NW]),
        .in_n     (n_c[NW]),
        .in_q1    (q1_c[NW]),
        .in_q2    (q2_c[NW]),
        .result   (result)
    );

`ifndef ASSERT_OFF
    // zero vector carries all-zero fields
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.zero_vector |->
            result.cell_index == '0 && result.face == FACE_NEG_X
            && result.cell_x == '0 && result.cell_y == '0)
        else $error("zero vector item with nonzero fields");

    // face code stays within the six faces
    a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.face <= FACE_POS_Z)
        else $error("face code out of range");

    // input stalls only when the pipe is full behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !dir_chan.ready |-> result.valid && !result.ready)
        else $error("input stalled with output free");
`endif

endmodule
